### rtl/sotb_pkg.sv
// ----------------------------------------------------------------------------
// sotb_pkg
// Shared types and constants of the sequenced top-of-book engine.
// ----------------------------------------------------------------------------
package sotb_pkg;

	localparam int PRICE_W = 31;
	localparam int QTY_W   = 31;
	localparam int SEQ_W   = 64;
	localparam int LVL_W   = PRICE_W + QTY_W;

	// Result status codes
	localparam logic [1:0] ST_APPLIED  = 2'd0;
	localparam logic [1:0] ST_BUFFERED = 2'd1;
	localparam logic [1:0] ST_DROPPED  = 2'd2;
	localparam logic [1:0] ST_RESYNC   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_START_SEQ = 2'd0;
	localparam logic [1:0] CFG_MAX_GAP   = 2'd1;

	localparam logic [5:0] MAX_GAP_RESET = 6'd8;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLASS,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_NEXT,
		S_DRN_RD,
		S_DRN_CHK,
		S_DONE
	} state_t;

endpackage

### rtl/sequenced_top_of_book_engine_top.sv
// ----------------------------------------------------------------------------
// sequenced_top_of_book_engine_top
// Sequence check, reorder window and sorted price-level books per side.
// ----------------------------------------------------------------------------
// Flow: a dropped or buffered request, or an applied unknown-side one,
//   finishes without a book access; any other applied request searches its
//   side's levels and may shift them to insert or delete; so does each entry
//   drained from the window. Throughput: one request at a time, the next
//   accepted once the result is registered; a stalled result holds the engine.
// Reset: arst_n clears control state, window valid bits and book counts.
// ----------------------------------------------------------------------------
module sequenced_top_of_book_engine_top
	import sotb_pkg::*;
#(
	parameter int WINDOW = 64,
	parameter int LEVELS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SEQ_W-1:0]  sequence_req,
	input  logic [1:0]        side,
	input  logic [PRICE_W-1:0] price,
	input  logic [QTY_W-1:0]  quantity,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic signed [31:0] best_bid,
	output logic signed [31:0] best_ask,
	output logic              top_changed,
	output logic [6:0]        applied_count,
	output logic              level_overflow,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [SEQ_W-1:0]  cfg_data
);

	localparam int WW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SDEPTH  = 1 << WW;
	localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW      = $clog2(LEVELS + 1);
	localparam int LDEPTH  = 2 << LW;
	localparam int GAP_CAP = WINDOW - 2;
	localparam int SLOT_W  = SEQ_W + 2 + LVL_W;

	state_t state_q, state_d;

	// request registers
	logic [SEQ_W-1:0]   seq_q;
	logic [1:0]         side_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	logic [1:0]         status_q;
	logic [6:0]         applied_q;
	logic               ovf_q;

	// sequencing state
	logic [SEQ_W-1:0]   exp_q;
	logic [5:0]         max_gap_q;
	logic [SDEPTH-1:0]  slot_valid_q;

	// book state
	logic [CW-1:0]      bid_cnt_q, ask_cnt_q;
	logic [PRICE_W-1:0] bid_top_q, ask_top_q;
	logic [63:0]        last_top_q;
	logic [CW-1:0]      i_q, k_q, n_ins_q;
	logic               found_q;

	// memories
	logic [SLOT_W-1:0]  slot_mem [SDEPTH];
	logic [SLOT_W-1:0]  slot_rdata_q;
	logic [LVL_W-1:0]   lvl_mem [LDEPTH];
	logic [LVL_W-1:0]   lvl_rdata_q;

	logic               slot_we;
	logic [LW:0]        lvl_raddr, lvl_waddr;
	logic               lvl_we;
	logic [LVL_W-1:0]   lvl_wdata;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [31:0]        out_bid_q, out_ask_q;
	logic               out_changed_q;
	logic [6:0]         out_applied_q;
	logic               out_ovf_q;

	// decode helpers
	logic [SEQ_W-1:0]   seq_diff;
	logic [SEQ_W-1:0]   eff_gap;
	logic [CW-1:0]      cur_n;
	logic [PRICE_W-1:0] rd_price;
	logic               rd_better;
	logic               full;
	logic [SEQ_W-1:0]   slot_seq;
	logic [63:0]        pair;
	logic               out_free;

	assign seq_diff  = seq_q - exp_q;
	assign eff_gap   = (32'(max_gap_q) > GAP_CAP) ? SEQ_W'(GAP_CAP) : SEQ_W'(max_gap_q);
	assign cur_n     = side_q[0] ? ask_cnt_q : bid_cnt_q;
	assign rd_price  = lvl_rdata_q[LVL_W-1:QTY_W];
	assign rd_better = side_q[0] ? (rd_price < price_q) : (rd_price > price_q);
	assign full      = (cur_n >= CW'(LEVELS));
	assign slot_seq  = slot_rdata_q[SLOT_W-1:SLOT_W-SEQ_W];
	assign pair      = {(bid_cnt_q != '0) ? {1'b0, bid_top_q} : 32'hFFFF_FFFF,
		(ask_cnt_q != '0) ? {1'b0, ask_top_q} : 32'hFFFF_FFFF};
	assign out_free  = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CLASS;
			end
			S_CLASS: begin
				if (seq_q == exp_q || (seq_q > exp_q && seq_diff > eff_gap)) begin
					state_d = side_q[1] ? S_NEXT : S_SRCH_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRCH_RD: state_d = (i_q >= cur_n) ? S_DECIDE : S_SRCH_CMP;
			S_SRCH_CMP: state_d = rd_better ? S_SRCH_RD : S_DECIDE;
			S_DECIDE: begin
				if (qty_q == '0) state_d = found_q ? S_DEL_RD : S_NEXT;
				else if (found_q) state_d = S_NEXT;
				else if (full && i_q >= cur_n) state_d = S_NEXT;
				else state_d = S_INS_RD;
			end
			S_INS_RD: state_d = (k_q == i_q) ? S_NEXT : S_INS_WR;
			S_INS_WR: state_d = S_INS_RD;
			S_DEL_RD: state_d = ({1'b0, k_q} + 1'b1 >= {1'b0, cur_n}) ? S_NEXT : S_DEL_WR;
			S_DEL_WR: state_d = S_DEL_RD;
			S_NEXT: state_d = S_DRN_RD;
			S_DRN_RD: state_d = slot_valid_q[exp_q[WW-1:0]] ? S_DRN_CHK : S_DONE;
			S_DRN_CHK: begin
				if (slot_seq == exp_q) begin
					state_d = slot_rdata_q[LVL_W+1] ? S_NEXT : S_SRCH_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory strobes
	always_comb begin
		slot_we   = 1'b0;
		lvl_we    = 1'b0;
		lvl_raddr = {side_q[0], i_q[LW-1:0]};
		lvl_waddr = {side_q[0], i_q[LW-1:0]};
		lvl_wdata = {price_q, qty_q};
		unique case (state_q)
			S_CLASS: begin
				slot_we = (seq_q > exp_q) && (seq_diff <= eff_gap);
			end
			S_DECIDE: begin
				lvl_we = (qty_q != '0) && found_q;
			end
			S_INS_RD: begin
				lvl_we    = (k_q == i_q);
				lvl_raddr = {side_q[0], LW'(k_q - 1'b1)};
			end
			S_INS_WR: begin
				lvl_we    = 1'b1;
				lvl_waddr = {side_q[0], k_q[LW-1:0]};
				lvl_wdata = lvl_rdata_q;
			end
			S_DEL_RD: begin
				lvl_raddr = {side_q[0], LW'(k_q + 1'b1)};
			end
			S_DEL_WR: begin
				lvl_we    = 1'b1;
				lvl_waddr = {side_q[0], k_q[LW-1:0]};
				lvl_wdata = lvl_rdata_q;
			end
			default: ;
		endcase
	end

	// Window memory
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[seq_q[WW-1:0]] <= {seq_q, side_q, price_q, qty_q};
		slot_rdata_q <= slot_mem[exp_q[WW-1:0]];
	end

	// Level memory, both sides
	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
		lvl_rdata_q <= lvl_mem[lvl_raddr];
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			exp_q         <= '0;
			max_gap_q     <= MAX_GAP_RESET;
			slot_valid_q  <= '0;
			bid_cnt_q     <= '0;
			ask_cnt_q     <= '0;
			last_top_q    <= '1;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_valid) begin
				if (cfg_index == CFG_START_SEQ) exp_q <= cfg_data;
				else if (cfg_index == CFG_MAX_GAP) max_gap_q <= cfg_data[5:0];
			end

			// track the best price on any write to the head entry
			if (lvl_we && lvl_waddr[LW-1:0] == '0) begin
				if (lvl_waddr[LW]) ask_top_q <= lvl_wdata[LVL_W-1:QTY_W];
				else bid_top_q <= lvl_wdata[LVL_W-1:QTY_W];
			end

			// publish a finished result, release it once taken
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						seq_q     <= sequence_req;
						side_q    <= side;
						price_q   <= price;
						qty_q     <= quantity;
						applied_q <= '0;
						ovf_q     <= 1'b0;
						i_q       <= '0;
					end
				end
				S_CLASS: begin
					if (seq_q == exp_q) begin
						status_q <= ST_APPLIED;
					end else if (seq_q < exp_q) begin
						status_q <= ST_DROPPED;
					end else if (seq_diff <= eff_gap) begin
						status_q <= ST_BUFFERED;
						slot_valid_q[seq_q[WW-1:0]] <= 1'b1;
					end else begin
						// resync: drop the window, restart on this request
						status_q     <= ST_RESYNC;
						slot_valid_q <= '0;
						exp_q        <= seq_q;
					end
				end
				S_SRCH_RD: begin
					if (i_q >= cur_n) found_q <= 1'b0;
				end
				S_SRCH_CMP: begin
					if (rd_better) i_q <= i_q + 1'b1;
					else found_q <= (rd_price == price_q);
				end
				S_DECIDE: begin
					if (qty_q == '0) begin
						k_q <= i_q;
					end else if (!found_q) begin
						if (full) begin
							ovf_q   <= 1'b1;
							k_q     <= CW'(LEVELS - 1);
							n_ins_q <= CW'(LEVELS);
						end else begin
							k_q     <= cur_n;
							n_ins_q <= cur_n + 1'b1;
						end
					end
				end
				S_INS_RD: begin
					if (k_q == i_q) begin
						if (side_q[0]) ask_cnt_q <= n_ins_q;
						else bid_cnt_q <= n_ins_q;
					end
				end
				S_INS_WR: k_q <= k_q - 1'b1;
				S_DEL_RD: begin
					if ({1'b0, k_q} + 1'b1 >= {1'b0, cur_n}) begin
						if (side_q[0]) ask_cnt_q <= cur_n - 1'b1;
						else bid_cnt_q <= cur_n - 1'b1;
					end
				end
				S_DEL_WR: k_q <= k_q + 1'b1;
				S_NEXT: begin
					exp_q <= exp_q + 1'b1;
					if (applied_q != 7'h7F) applied_q <= applied_q + 1'b1;
				end
				S_DRN_CHK: begin
					// take the held request as the next one to apply
					if (slot_seq == exp_q) begin
						slot_valid_q[exp_q[WW-1:0]] <= 1'b0;
						side_q  <= slot_rdata_q[LVL_W+1:LVL_W];
						price_q <= slot_rdata_q[LVL_W-1:QTY_W];
						qty_q   <= slot_rdata_q[QTY_W-1:0];
						i_q     <= '0;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q  <= status_q;
						out_bid_q     <= pair[63:32];
						out_ask_q     <= pair[31:0];
						out_changed_q <= (applied_q != '0) && (pair != last_top_q);
						out_applied_q <= applied_q;
						out_ovf_q     <= ovf_q;
						if (applied_q != '0) last_top_q <= pair;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign best_bid       = out_bid_q;
	assign best_ask       = out_ask_q;
	assign top_changed    = out_changed_q;
	assign applied_count  = out_applied_q;
	assign level_overflow = out_ovf_q;

endmodule

### rtl/sotb_checker.sv
// ----------------------------------------------------------------------------
// sotb_checker
// Port-level checks of the top-of-book engine, bound to the top level.
// ----------------------------------------------------------------------------
module sotb_checker
	import sotb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        status,
	input logic signed [31:0] best_bid,
	input logic signed [31:0] best_ask,
	input logic              top_changed,
	input logic [6:0]        applied_count
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(best_bid)
			&& $stable(best_ask) && $stable(applied_count))
		else $error("stalled result changed");

	// buffered and dropped requests apply nothing
	a_noapply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BUFFERED || status == ST_DROPPED)
			|-> applied_count == '0 && !top_changed)
		else $error("non-applying request reported work");

	// applying requests count at least one update
	a_apply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_APPLIED || status == ST_RESYNC) |-> applied_count != '0)
		else $error("applying request reported no update");

	// a negative price only means an empty side
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!best_bid[31] || best_bid == -32'sd1)
			&& (!best_ask[31] || best_ask == -32'sd1))
		else $error("bad empty-side price");

endmodule

bind sequenced_top_of_book_engine_top sotb_checker u_sotb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.best_bid      (best_bid),
	.best_ask      (best_ask),
	.top_changed   (top_changed),
	.applied_count (applied_count)
);
